// File: src/bmh_pkg.sv
// Package for the binary min-heap block: transaction types, action codes
// and the command/status structs between controller and datapath. No dependencies.
package bmh_pkg;

    // Action codes carried in the input transaction
    typedef enum logic [1:0] {
        ACT_APPEND = 2'd0,
        ACT_BUILD  = 2'd1,
        ACT_INSERT = 2'd2,
        ACT_NOP    = 2'd3
    } t_action;

    typedef struct packed {
        logic [1:0]         action;
        logic signed [31:0] key;
        logic [31:0]        payload;
    } t_in;

    typedef struct packed {
        logic               status;
        logic [10:0]        entry_count;
        logic               empty_res;
        logic signed [31:0] top_key;
        logic [31:0]        top_payload;
    } t_out;

    // Read address select
    typedef enum logic [1:0] {
        RD_PARENT = 2'd0,
        RD_LEFT   = 2'd1,
        RD_RIGHT  = 2'd2,
        RD_BUILD  = 2'd3
    } t_rd_sel;

    // Write data select
    typedef enum logic [1:0] {
        WR_REC   = 2'd0,
        WR_RDATA = 2'd1,
        WR_LREC  = 2'd2
    } t_wr_src;

    // Position register load select
    typedef enum logic [2:0] {
        POS_COUNT  = 3'd0,
        POS_PARENT = 3'd1,
        POS_LEFT   = 3'd2,
        POS_RIGHT  = 3'd3,
        POS_BUILD  = 3'd4
    } t_pos_sel;

    typedef struct packed {
        logic     load_in;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wr_src  wr_src;
        logic     wr_at_count;
        logic     pos_en;
        t_pos_sel pos_sel;
        logic     count_inc;
        logic     bi_init;
        logic     bi_dec;
        logic     rec_ld_rd;
        logic     lrec_ld;
        logic     set_full;
    } t_dp_cmd;

    typedef struct packed {
        logic [1:0] action;
        logic       full;
        logic       pos_zero;
        logic       bi_zero;
        logic       has_left;
        logic       has_right;
        logic       up_less;
        logic       go_left;
        logic       go_right;
    } t_dp_stat;

endpackage

// File: src/binary_min_heap_insert_build_top.sv
// Top level of the binary min-heap: controller plus datapath.
// Depends on bmh_pkg, bmh_ctrl, bmh_datapath.
//
// Usage: drive i_in and raise start while busy is low; the transaction is
// taken at that edge and busy rises. One result comes back per transaction
// on o_res, valid for exactly one cycle while o_done is high; the receiver
// cannot stall it. busy drops the cycle after o_done.
// Append, no-op or a rejected (full) transaction goes straight from dispatch
// to the result. Insert climbs level by level toward the root; each level
// needs one registered read of the record store and one write, through its
// single read and single write port.
// Build sifts each parent down, last to first; each level reads left and
// right child one after another from the one read port.
// One transaction is worked at a time; the next can be taken in the cycle
// after o_done.
// Reset empties the heap (count zero); the store contents are not cleared
// and need no clearing pass, since only entries below the count are read.
module binary_min_heap_insert_build_top #(
    parameter int CAPACITY     = 1024,
    parameter int RECORD_WORDS = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  bmh_pkg::t_in  i_in,
    output logic          busy,
    output logic          o_done,
    output bmh_pkg::t_out o_res
);
    import bmh_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    bmh_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy),
        .o_done  (o_done)
    );

    bmh_datapath #(
        .CAPACITY     (CAPACITY),
        .RECORD_WORDS (RECORD_WORDS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .o_res   (o_res)
    );

    // A taken transaction keeps the block busy next cycle
    a_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("busy did not rise");

    // After a result the block is free again
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy) else $error("busy after result");

    // A rejection only happens at full capacity
    a_full_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.status |-> o_res.entry_count == 11'(CAPACITY))
        else $error("rejected below capacity");

    // Empty heap reports a zero root
    a_empty_root: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_res.empty_res |-> o_res.top_key == 0 && o_res.top_payload == 0)
        else $error("nonzero root when empty");

endmodule

// File: src/bmh_datapath.sv
// Heap datapath: record store, count, position and record registers, compares.
// Depends on bmh_pkg.
module bmh_datapath #(
    parameter int CAPACITY     = 1024,
    parameter int RECORD_WORDS = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bmh_pkg::t_in     i_in,
    input  bmh_pkg::t_dp_cmd i_cmd,
    output bmh_pkg::t_dp_stat o_stat,
    output bmh_pkg::t_out    o_res
);
    import bmh_pkg::*;

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = CW + 1;
    localparam int RW = 32 * RECORD_WORDS;

    logic [RW-1:0] mem [CAPACITY];
    logic [RW-1:0] r_rdata;
    logic [RW-1:0] r_rec, r_lrec, r_root;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_pos, n_pos;
    logic [AW-1:0] r_bi;
    logic [1:0]    r_action;
    logic          r_full_flag;

    logic [EW-1:0] left_e, right_e, count_e;
    logic [AW-1:0] parent, bi_m1, rd_addr, wr_addr;
    logic [RW-1:0] wr_data, rec_in;
    logic signed [31:0] k_rec, k_rd, k_l;
    logic          right_lt, left_lt_rd, left_lt;

    // Tree index arithmetic
    assign count_e = EW'(r_count);
    assign left_e  = (EW'(r_pos) << 1) + EW'(1);
    assign right_e = left_e + EW'(1);
    assign parent  = (r_pos - AW'(1)) >> 1;
    assign bi_m1   = r_bi - AW'(1);
    assign rec_in  = RW'({i_in.payload, i_in.key});

    // Key compares (signed)
    assign k_rec      = $signed(r_rec[31:0]);
    assign k_rd       = $signed(r_rdata[31:0]);
    assign k_l        = $signed(r_lrec[31:0]);
    assign right_lt   = (right_e < count_e) && (k_rd < k_rec);
    assign left_lt_rd = k_l < k_rd;
    assign left_lt    = k_l < k_rec;

    always_comb begin
        o_stat.action    = r_action;
        o_stat.full      = r_count >= CW'(CAPACITY);
        o_stat.pos_zero  = r_pos == '0;
        o_stat.bi_zero   = r_bi == '0;
        o_stat.has_left  = left_e < count_e;
        o_stat.has_right = right_e < count_e;
        o_stat.up_less   = k_rec < k_rd;
        o_stat.go_right  = right_lt && !left_lt_rd;
        o_stat.go_left   = right_lt ? left_lt_rd : left_lt;
    end

    // Address and data selection
    always_comb begin
        case (i_cmd.rd_sel)
            RD_PARENT: rd_addr = parent;
            RD_LEFT:   rd_addr = left_e[AW-1:0];
            RD_RIGHT:  rd_addr = right_e[AW-1:0];
            default:   rd_addr = bi_m1;
        endcase
        case (i_cmd.wr_src)
            WR_RDATA: wr_data = r_rdata;
            WR_LREC:  wr_data = r_lrec;
            default:  wr_data = r_rec;
        endcase
        wr_addr = i_cmd.wr_at_count ? AW'(r_count) : r_pos;
        case (i_cmd.pos_sel)
            POS_COUNT:  n_pos = AW'(r_count);
            POS_PARENT: n_pos = parent;
            POS_LEFT:   n_pos = left_e[AW-1:0];
            POS_RIGHT:  n_pos = right_e[AW-1:0];
            default:    n_pos = bi_m1;
        endcase
        n_count = i_cmd.count_inc ? r_count + CW'(1) : r_count;
    end

    // Record store: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_full_flag <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load_in) begin
                r_full_flag <= 1'b0;
            end else if (i_cmd.set_full) begin
                r_full_flag <= 1'b1;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_action <= i_in.action;
            r_rec    <= rec_in;
        end else if (i_cmd.rec_ld_rd) begin
            r_rec <= r_rdata;
        end
        if (i_cmd.lrec_ld) begin
            r_lrec <= r_rdata;
        end
        if (i_cmd.pos_en) begin
            r_pos <= n_pos;
        end
        if (i_cmd.bi_init) begin
            r_bi <= AW'(r_count >> 1);
        end else if (i_cmd.bi_dec) begin
            r_bi <= bi_m1;
        end
        // Shadow copy of the root record
        if (i_cmd.wr_en && wr_addr == '0) begin
            r_root <= wr_data;
        end
    end

    // Result fields
    always_comb begin
        o_res.status      = r_full_flag;
        o_res.entry_count = 11'(r_count);
        o_res.empty_res   = r_count == '0;
        o_res.top_key     = (r_count == '0) ? '0 : $signed(r_root[31:0]);
        o_res.top_payload = (r_count == '0) ? '0 : 32'(64'(r_root) >> 32);
    end

endmodule

// File: src/bmh_ctrl.sv
// Heap controller: state machine sequencing append, build and insert.
// Depends on bmh_pkg.
module bmh_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  bmh_pkg::t_dp_stat i_stat,
    output bmh_pkg::t_dp_cmd  o_cmd,
    output logic              o_busy,
    output logic              o_done
);
    import bmh_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_DISP   = 10'b0000000010,
        S_UP_CHK = 10'b0000000100,
        S_UP_CMP = 10'b0000001000,
        S_BLD    = 10'b0000010000,
        S_DN_LD  = 10'b0000100000,
        S_DN_RL  = 10'b0001000000,
        S_DN_RR  = 10'b0010000000,
        S_DN_CMP = 10'b0100000000,
        S_DONE   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = r_state != S_IDLE;
    assign o_done = r_state == S_DONE;

    // Next state and datapath commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.rd_sel  = RD_PARENT;
        o_cmd.wr_src  = WR_REC;
        o_cmd.pos_sel = POS_COUNT;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DISP;
                end
            end
            S_DISP: begin
                n_state = S_DONE;
                if (i_stat.action == ACT_APPEND || i_stat.action == ACT_INSERT) begin
                    if (i_stat.full) begin
                        o_cmd.set_full = 1'b1;
                    end else if (i_stat.action == ACT_APPEND) begin
                        o_cmd.wr_en       = 1'b1;
                        o_cmd.wr_at_count = 1'b1;
                        o_cmd.count_inc   = 1'b1;
                    end else begin
                        o_cmd.pos_en    = 1'b1;
                        o_cmd.count_inc = 1'b1;
                        n_state = S_UP_CHK;
                    end
                end else if (i_stat.action == ACT_BUILD) begin
                    o_cmd.bi_init = 1'b1;
                    n_state = S_BLD;
                end
            end
            // Sift-up: hole moves toward the root
            S_UP_CHK: begin
                if (i_stat.pos_zero) begin
                    o_cmd.wr_en = 1'b1;
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en = 1'b1;
                    n_state = S_UP_CMP;
                end
            end
            S_UP_CMP: begin
                o_cmd.wr_en = 1'b1;
                if (i_stat.up_less) begin
                    o_cmd.wr_src  = WR_RDATA;
                    o_cmd.pos_en  = 1'b1;
                    o_cmd.pos_sel = POS_PARENT;
                    n_state = S_UP_CHK;
                end else begin
                    n_state = S_DONE;
                end
            end
            // Build: next parent, last to first
            S_BLD: begin
                if (i_stat.bi_zero) begin
                    n_state = S_DONE;
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = RD_BUILD;
                    o_cmd.pos_en  = 1'b1;
                    o_cmd.pos_sel = POS_BUILD;
                    o_cmd.bi_dec  = 1'b1;
                    n_state = S_DN_LD;
                end
            end
            S_DN_LD: begin
                o_cmd.rec_ld_rd = 1'b1;
                n_state = S_DN_RL;
            end
            S_DN_RL: begin
                if (!i_stat.has_left) begin
                    o_cmd.wr_en = 1'b1;
                    n_state = S_BLD;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_LEFT;
                    n_state = S_DN_RR;
                end
            end
            S_DN_RR: begin
                o_cmd.lrec_ld = 1'b1;
                if (i_stat.has_right) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = RD_RIGHT;
                end
                n_state = S_DN_CMP;
            end
            S_DN_CMP: begin
                o_cmd.wr_en  = 1'b1;
                o_cmd.pos_en = 1'b1;
                if (i_stat.go_right) begin
                    o_cmd.wr_src  = WR_RDATA;
                    o_cmd.pos_sel = POS_RIGHT;
                    n_state = S_DN_RL;
                end else if (i_stat.go_left) begin
                    o_cmd.wr_src  = WR_LREC;
                    o_cmd.pos_sel = POS_LEFT;
                    n_state = S_DN_RL;
                end else begin
                    o_cmd.pos_en = 1'b0;
                    n_state = S_BLD;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for binary_min_heap_insert_build_top: a heap scoreboard class
// predicts status, count and root for every command; plain tasks drive it.
// Depends on bmh_pkg and the RTL of the block.
module tb;
    import bmh_pkg::*;

    localparam int CAP        = 1024;
    localparam int LIMIT_CYC  = 12000000;
    localparam int N_RANDOM   = 1930;
    localparam int SETTLE_CYC = 40;

    // Heap scoreboard: its own copy of the record store
    class heap_scoreboard;
        logic signed [31:0] keys [CAP];
        logic [31:0]        pays [CAP];
        int unsigned        fill;
        t_out               pending [$];
        int                 n_err;

        function new();
            fill  = 0;
            n_err = 0;
        endfunction

        function void swap_rec(int unsigned a, int unsigned b);
            logic signed [31:0] tk;
            logic [31:0]        tp;
            tk = keys[a]; tp = pays[a];
            keys[a] = keys[b]; pays[a] = pays[b];
            keys[b] = tk; pays[b] = tp;
        endfunction

        // right child wins ties and wins when only it is smaller
        function void sift_down(int unsigned pos);
            int unsigned l, r, pick;
            forever begin
                l = 2 * pos + 1;
                r = 2 * pos + 2;
                pick = pos;
                if (r < fill && keys[r] < keys[pos]) begin
                    pick = (keys[l] < keys[r]) ? l : r;
                end else if (l < fill && keys[l] < keys[pos]) begin
                    pick = l;
                end
                if (pick == pos) return;
                swap_rec(pos, pick);
                pos = pick;
            end
        endfunction

        // climbs only while strictly smaller than the parent
        function void sift_up(int unsigned pos);
            int unsigned par;
            while (pos > 0) begin
                par = (pos - 1) / 2;
                if (!(keys[pos] < keys[par])) return;
                swap_rec(pos, par);
                pos = par;
            end
        endfunction

        // Accepted command: update the heap and queue the expected result
        function void note_command(t_in cmd);
            t_out        res;
            t_action     act;
            int unsigned i;
            act = t_action'(cmd.action);
            res = '0;
            if (act == ACT_APPEND || act == ACT_INSERT) begin
                if (fill >= CAP) begin
                    res.status = 1'b1;
                end else begin
                    keys[fill] = cmd.key;
                    pays[fill] = cmd.payload;
                    fill++;
                    if (act == ACT_INSERT) sift_up(fill - 1);
                end
            end else if (act == ACT_BUILD) begin
                i = fill / 2;
                while (i > 0) begin
                    i--;
                    sift_down(i);
                end
            end
            res.entry_count = fill[10:0];
            res.empty_res   = (fill == 0);
            if (fill != 0) begin
                res.top_key     = keys[0];
                res.top_payload = pays[0];
            end
            pending.push_back(res);
        endfunction

        function void check_result(t_out got);
            t_out exp_res;
            if (pending.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result: %p", got);
                return;
            end
            exp_res = pending.pop_front();
            if (got.status !== exp_res.status || got.entry_count !== exp_res.entry_count ||
                got.empty_res !== exp_res.empty_res || got.top_key !== exp_res.top_key ||
                got.top_payload !== exp_res.top_payload) begin
                n_err++;
                if (n_err <= 10)
                    $display("mismatch at %0t: expected %p got %p", $time, exp_res, got);
            end
        endfunction
    endclass

    logic   i_clk = 1'b0;
    logic   i_rst_n;
    logic   start;
    t_in    i_in;
    logic   busy;
    logic   o_done;
    t_out   o_res;
    int     cyc = 0;
    int     idle_pct;
    heap_scoreboard sb = new();

    binary_min_heap_insert_build_top #(.CAPACITY(CAP), .RECORD_WORDS(2)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .i_in(i_in),
        .busy(busy), .o_done(o_done), .o_res(o_res)
    );

    always #4 i_clk = ~i_clk;

    // Watch both handshakes at each edge
    always @(posedge i_clk) begin
        if (i_rst_n && start && !busy) sb.note_command(i_in);
        if (i_rst_n && o_done) sb.check_result(o_res);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= LIMIT_CYC) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // One transaction: hold start until taken, then maybe go idle a while
    task automatic issue(input t_action act, input logic [31:0] key, input logic [31:0] pay);
        t_in cmd;
        cmd.action  = act;
        cmd.key     = key;
        cmd.payload = pay;
        i_in  <= cmd;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        if ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
        end
    endtask

    // Stop and let every outstanding result come back
    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
    endtask

    task automatic random_item();
        int          pick;
        logic [31:0] key;
        t_action     act;
        pick = $urandom_range(99);
        if (pick < 45)      act = ACT_APPEND;
        else if (pick < 85) act = ACT_INSERT;
        else if (pick < 95) act = ACT_BUILD;
        else                act = ACT_NOP;
        // narrow keys give plenty of ties
        case ($urandom_range(3))
            0:       key = $urandom_range(0, 7) - 4;
            1:       key = $urandom_range(0, 200) - 100;
            default: key = $urandom;
        endcase
        issue(act, key, $urandom);
    endtask

    initial begin
        int ph;
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_in    <= '0;
        idle_pct = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty heap, single entry, child tie, extremes, equal-key climb
        issue(ACT_NOP,    32'h0, 32'h0);
        issue(ACT_BUILD,  32'h0, 32'hFFFF_FFFF);
        issue(ACT_APPEND, 32'd5, 32'h0);
        issue(ACT_BUILD,  32'h0, 32'h0);
        issue(ACT_APPEND, 32'd3, 32'hAAAA_AAAA);
        issue(ACT_APPEND, 32'd3, 32'h5555_5555);
        issue(ACT_BUILD,  32'h0, 32'h0);
        issue(ACT_APPEND, 32'd9, 32'h1);
        issue(ACT_APPEND, 32'd8, 32'h2);
        issue(ACT_APPEND, 32'd4, 32'h3);
        issue(ACT_BUILD,  32'h0, 32'h0);
        issue(ACT_INSERT, 32'd3, 32'hFFFF_FFFF);
        issue(ACT_INSERT, 32'h7FFF_FFFF, 32'h1234_5678);
        issue(ACT_INSERT, 32'h8000_0000, 32'h8765_4321);
        issue(ACT_INSERT, 32'h8000_0000, 32'h0);
        issue(ACT_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        issue(ACT_INSERT, 32'h0, 32'h0);
        issue(ACT_APPEND, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        issue(ACT_APPEND, 32'h8000_0000, 32'h0);
        issue(ACT_BUILD,  32'h0, 32'h0);
        issue(ACT_NOP,    32'hFFFF_FFFF, 32'hFFFF_FFFF);
        drain();

        // Random phases: no idling, heavy idling, moderate idling, none again
        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: idle_pct = 0;
                1: idle_pct = 81;
                2: idle_pct = 38;
                default: idle_pct = 0;
            endcase
            repeat (N_RANDOM / 4) random_item();
            drain();
        end

        // Make sure the full store is hit, then work on it a bit
        idle_pct = 20;
        while (sb.fill < CAP) issue(ACT_APPEND, $urandom, $urandom);
        repeat (8) random_item();
        issue(ACT_BUILD, 32'h0, 32'h0);
        issue(ACT_INSERT, $urandom, $urandom);

        start <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (sb.n_err == 0 && sb.pending.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
